/* rtl/core/emrs_pkg.sv */
package emrs_pkg;

  localparam int unsigned RAW_FIELD_W = 24;
  localparam int unsigned RES_W       = 32;
  localparam int unsigned FLAG_W      = 2;
  localparam int unsigned VAR_W       = 2;

  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 48;
  localparam int unsigned REF_V_W     = 10;
  localparam int unsigned REF_I_W     = 17;
  localparam int unsigned CAL_VI_W    = 48;
  localparam int unsigned CAL_K_W     = 24;
  localparam int unsigned CAL_PW_W    = 23;
  localparam int unsigned CHIP_VAR_W  = 2 * VAR_W;

  localparam logic [REF_V_W-1:0] REF_V_RST = 10'd220;
  localparam logic [REF_I_W-1:0] REF_I_RST = 17'd135;

  // shared multiplier and divider widths
  localparam int unsigned MOP_W    = 27;
  localparam int unsigned PROD_W   = 2 * MOP_W;
  localparam int unsigned VI_W     = REF_V_W + REF_I_W;
  localparam int unsigned VK_W     = 20;
  localparam int unsigned NUM_W    = 67;
  localparam int unsigned DEN_W    = 43;
  localparam int unsigned HI_W     = NUM_W - RES_W;
  localparam int unsigned CNT_W    = $clog2(RES_W);
  localparam int unsigned NUM_SH_W = 5;

  localparam logic [MOP_W-1:0] MUL_UNIT  = 27'd1;
  localparam logic [MOP_W-1:0] MV_PER_V  = 27'd1000;
  localparam logic [MOP_W-1:0] PW_DEN_K  = 27'd1000;
  localparam logic [MOP_W-1:0] EN_DEN_K  = 27'd703125;

  localparam logic [NUM_SH_W-1:0] EN_SH_D78 = 5'd16;
  localparam logic [NUM_SH_W-1:0] EN_SH_D7X = 5'd2;
  localparam logic [NUM_SH_W-1:0] EN_SH_NONE = 5'd0;

  localparam logic [RAW_FIELD_W-1:0] GAIN_OK = 24'h000033;
  localparam int unsigned            OV_BIT  = 5;

  localparam logic [RES_W-1:0] SAT_VAL  = '1;
  localparam logic [RES_W-1:0] VOLT_MIN = 32'd1000;
  localparam logic [RES_W-1:0] CURR_MIN = 32'd10;

  localparam logic [FLAG_W-1:0] FLAG_COMM_ERR = 2'b01;
  localparam logic [FLAG_W-1:0] FLAG_OVER_V   = 2'b10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REF_VOLTAGE   = 3'd0,
    CFG_REF_CURRENT   = 3'd1,
    CFG_CAL_VI_CH0    = 3'd2,
    CFG_CAL_VI_CH1    = 3'd3,
    CFG_CAL_POWER_CH0 = 3'd4,
    CFG_CAL_POWER_CH1 = 3'd5,
    CFG_CHIP_VARIANTS = 3'd6
  } cfg_idx_e;

  typedef enum logic [VAR_W-1:0] {
    VAR_UNKNOWN = 2'd0,
    VAR_D78     = 2'd1,
    VAR_D70     = 2'd2,
    VAR_D75     = 2'd3
  } variant_e;

  typedef enum logic [1:0] {
    QTY_VOLT   = 2'd0,
    QTY_CURR   = 2'd1,
    QTY_POWER  = 2'd2,
    QTY_ENERGY = 2'd3
  } qty_e;

  typedef struct packed {
    logic                   channel;
    logic [RAW_FIELD_W-1:0] gain_reading;
    logic [RAW_FIELD_W-1:0] status_reading;
    logic [RAW_FIELD_W-1:0] volt_rms_raw;
    logic [RAW_FIELD_W-1:0] curr_rms_raw;
    logic [RAW_FIELD_W-1:0] power_raw;
    logic [RAW_FIELD_W-1:0] pulse_count_raw;
  } in_word_t;

  typedef struct packed {
    logic              out_channel;
    logic [RES_W-1:0]  voltage_mv;
    logic [RES_W-1:0]  current_ma;
    logic [RES_W-1:0]  power_w;
    logic [RES_W-1:0]  energy_centi;
    logic [FLAG_W-1:0] chip_state;
    logic              comm_error;
  } out_word_t;

endpackage

/* rtl/core/emrs_chan_if.sv */
interface emrs_chan_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

/* rtl/core/energy_meter_reading_scaler_core.sv */
// Energy meter reading scaler.
// in_i (emrs_chan_if.sink, in_word_t) takes one word of raw readings for one
// channel; out_o (emrs_chan_if.source, out_word_t) returns one word of scaled
// results per input word. Calibration is written through cfg_we_i / cfg_idx_i /
// cfg_wdata_i, which the user must do only while no word is in flight; the block
// does not enforce this. All conversions share one 27x27 multiplier and one
// radix-2 restoring divider (one quotient bit per cycle, 32 bits). in_i.ready is
// high only in idle. Per input word the arithmetic runs four divisions, one per
// quantity; a division is skipped for a quantity whose divisor is zero or whose
// quotient saturates, and a gain mismatch skips the arithmetic altogether.
// The result sits in an output register, so the next word is accepted while
// the receiver stalls; only the write into that register waits for it.
// Reset (rst_ni low, asynchronous) loads the calibration defaults (220 V,
// 135 mA, zero counts, unknown variants) and clears the per-channel flags and
// stored results; the block is ready on the first cycle after reset.
module energy_meter_reading_scaler_core
  import emrs_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 2,
  parameter int unsigned RAW_WIDTH    = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  emrs_chan_if.sink             in_i,
  emrs_chan_if.source           out_o
);

  localparam int unsigned ChIdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned RawEff = (RAW_WIDTH < RAW_FIELD_W) ? RAW_WIDTH : RAW_FIELD_W;
  localparam logic [RAW_FIELD_W-1:0] RawMask =
    RAW_FIELD_W'((64'd1 << RawEff) - 64'd1);
  localparam logic [RAW_FIELD_W-1:0] PwMask =
    (RAW_WIDTH <= RAW_FIELD_W) ? (RawMask >> 1) : RawMask;
  localparam logic [CNT_W-1:0] LastCnt = CNT_W'(RES_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE_VI,
    ST_PRE_VK,
    ST_MUL_NUM,
    ST_MUL_DEN,
    ST_DIV_CHK,
    ST_DIV_RUN,
    ST_FINISH
  } state_e;

  state_e                 st_q;
  qty_e                   qty_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   out_valid_q;
  out_word_t              out_word_q;

  logic [REF_V_W-1:0]     ref_v_q;
  logic [REF_I_W-1:0]     ref_i_q;
  logic [CAL_VI_W-1:0]    cal_vi_q [2];
  logic [CAL_PW_W-1:0]    cal_pw_q [2];
  logic [CHIP_VAR_W-1:0]  chip_var_q;

  logic [FLAG_W-1:0]      flags_q  [NUM_CHANNELS];
  logic [RES_W-1:0]       last_v_q [NUM_CHANNELS];
  logic [RES_W-1:0]       last_i_q [NUM_CHANNELS];
  logic [RES_W-1:0]       last_p_q [NUM_CHANNELS];
  logic [RES_W-1:0]       last_e_q [NUM_CHANNELS];

  logic                   chan_q;
  logic [ChIdxW-1:0]      ch_idx_q;
  logic                   err_q;
  logic                   status_ov_q;
  logic [RAW_FIELD_W-1:0] vrms_q;
  logic [RAW_FIELD_W-1:0] irms_q;
  logic [RAW_FIELD_W-1:0] pw_q;
  logic [RAW_FIELD_W-1:0] pulses_q;
  logic [VI_W-1:0]        vi_q;
  logic [VK_W-1:0]        vk_q;
  logic [NUM_W-1:0]       num_q;
  logic [DEN_W-1:0]       den_q;
  logic [DEN_W-1:0]       rem_q;
  logic [RES_W-1:0]       quo_q;
  logic [RES_W-1:0]       res_q [4];

  logic [MOP_W-1:0]       mul_a;
  logic [MOP_W-1:0]       mul_b;
  logic [PROD_W-1:0]      prod;
  variant_e               variant;
  logic [CAL_K_W-1:0]     uk;
  logic [CAL_K_W-1:0]     ik;
  logic [CAL_PW_W-1:0]    wk;
  logic [NUM_SH_W-1:0]    num_sh;
  logic                   sat_chk;
  logic [DEN_W+1:0]       diff;
  logic                   ge;
  logic [DEN_W-1:0]       rem_d;
  logic [RES_W-1:0]       quo_d;
  logic [RES_W-1:0]       res_raw;
  logic [RES_W-1:0]       res_fin;
  logic                   res_we;
  logic                   out_free;
  logic [FLAG_W-1:0]      flags_d;

  assign in_i.ready  = (st_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.word  = out_word_q;

  // calibration of the channel being processed
  always_comb begin
    variant = variant_e'(chan_q ? chip_var_q[CHIP_VAR_W-1:VAR_W] : chip_var_q[VAR_W-1:0]);
    uk      = cal_vi_q[chan_q][CAL_VI_W-1:CAL_K_W];
    ik      = cal_vi_q[chan_q][CAL_K_W-1:0];
    wk      = cal_pw_q[chan_q];
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_q)
      ST_PRE_VI: begin
        mul_a = MOP_W'(ref_v_q);
        mul_b = MOP_W'(ref_i_q);
      end
      ST_PRE_VK: begin
        mul_a = MOP_W'(ref_v_q);
        mul_b = MV_PER_V;
      end
      ST_MUL_NUM: begin
        case (qty_q)
          QTY_VOLT: begin
            mul_a = MOP_W'(vrms_q);
            mul_b = MOP_W'(vk_q);
          end
          QTY_CURR: begin
            mul_a = MOP_W'(irms_q);
            mul_b = MOP_W'(ref_i_q);
          end
          QTY_POWER: begin
            mul_a = MOP_W'(pw_q);
            mul_b = MOP_W'(vi_q);
          end
          default: begin
            mul_a = MOP_W'(pulses_q);
            mul_b = MOP_W'(vi_q);
          end
        endcase
      end
      ST_MUL_DEN: begin
        case (qty_q)
          QTY_VOLT: begin
            mul_a = MOP_W'(uk);
            mul_b = MUL_UNIT;
          end
          QTY_CURR: begin
            mul_a = MOP_W'(ik);
            mul_b = MUL_UNIT;
          end
          QTY_POWER: begin
            mul_a = MOP_W'(wk);
            mul_b = PW_DEN_K;
          end
          default: begin
            mul_a = MOP_W'(wk);
            mul_b = EN_DEN_K;
          end
        endcase
      end
      default: ;
    endcase
    prod = mul_a * mul_b;
  end

  // energy dividend scale: x65536 for D78, x4 for D70/D75, none for unknown
  always_comb begin
    num_sh = EN_SH_NONE;
    if (qty_q == QTY_ENERGY) begin
      case (variant)
        VAR_D78: num_sh = EN_SH_D78;
        VAR_D70: num_sh = EN_SH_D7X;
        VAR_D75: num_sh = EN_SH_D7X;
        default: num_sh = EN_SH_NONE;
      endcase
    end
  end

  // divider step and result finishing
  always_comb begin
    sat_chk = (den_q == '0) || (DEN_W'(num_q[NUM_W-1:RES_W]) >= den_q);
    diff    = {1'b0, rem_q, quo_q[RES_W-1]} - {2'b00, den_q};
    ge      = ~diff[DEN_W+1];
    rem_d   = ge ? diff[DEN_W-1:0] : {rem_q[DEN_W-2:0], quo_q[RES_W-1]};
    quo_d   = {quo_q[RES_W-2:0], ge};
    res_raw = (st_q == ST_DIV_CHK) ? SAT_VAL : quo_d;
    res_fin = res_raw;
    case (qty_q)
      QTY_VOLT:   if (res_raw < VOLT_MIN) res_fin = '0;
      QTY_CURR:   if (res_raw < CURR_MIN) res_fin = '0;
      QTY_ENERGY: if (variant == VAR_UNKNOWN) res_fin = '0;
      default:    ;
    endcase
    res_we = ((st_q == ST_DIV_CHK) && sat_chk) ||
             ((st_q == ST_DIV_RUN) && (cnt_q == LastCnt));
  end

  always_comb begin
    out_free = !out_valid_q || out_o.ready;
    if (err_q) begin
      flags_d = flags_q[ch_idx_q] | FLAG_COMM_ERR;
    end else if (status_ov_q) begin
      flags_d = flags_q[ch_idx_q] | FLAG_OVER_V;
    end else begin
      flags_d = '0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          chan_q      <= in_i.word.channel;
          ch_idx_q    <= (int'(in_i.word.channel) >= NUM_CHANNELS) ?
                         ChIdxW'(NUM_CHANNELS - 1) : ChIdxW'(in_i.word.channel);
          err_q       <= (in_i.word.gain_reading != GAIN_OK);
          status_ov_q <= in_i.word.status_reading[OV_BIT];
          vrms_q      <= in_i.word.volt_rms_raw & RawMask;
          irms_q      <= in_i.word.curr_rms_raw & RawMask;
          pw_q        <= in_i.word.power_raw & PwMask;
          pulses_q    <= in_i.word.pulse_count_raw & RawMask;
        end
      end
      ST_PRE_VI:  vi_q  <= VI_W'(prod);
      ST_PRE_VK:  vk_q  <= VK_W'(prod);
      ST_MUL_NUM: num_q <= NUM_W'(prod) << num_sh;
      ST_MUL_DEN: den_q <= DEN_W'(prod);
      ST_DIV_CHK: begin
        rem_q <= DEN_W'(num_q[NUM_W-1:RES_W]);
        quo_q <= num_q[RES_W-1:0];
      end
      ST_DIV_RUN: begin
        rem_q <= rem_d;
        quo_q <= quo_d;
      end
      default: ;
    endcase
    if (res_we) begin
      res_q[qty_q] <= res_fin;
    end
  end

  // sequencer, output register, configuration and per-channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      qty_q       <= QTY_VOLT;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
      ref_v_q     <= REF_V_RST;
      ref_i_q     <= REF_I_RST;
      cal_vi_q[0] <= '0;
      cal_vi_q[1] <= '0;
      cal_pw_q[0] <= '0;
      cal_pw_q[1] <= '0;
      chip_var_q  <= '0;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        flags_q[k]  <= '0;
        last_v_q[k] <= '0;
        last_i_q[k] <= '0;
        last_p_q[k] <= '0;
        last_e_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_REF_VOLTAGE:   ref_v_q     <= cfg_wdata_i[REF_V_W-1:0];
          CFG_REF_CURRENT:   ref_i_q     <= cfg_wdata_i[REF_I_W-1:0];
          CFG_CAL_VI_CH0:    cal_vi_q[0] <= cfg_wdata_i[CAL_VI_W-1:0];
          CFG_CAL_VI_CH1:    cal_vi_q[1] <= cfg_wdata_i[CAL_VI_W-1:0];
          CFG_CAL_POWER_CH0: cal_pw_q[0] <= cfg_wdata_i[CAL_PW_W-1:0];
          CFG_CAL_POWER_CH1: cal_pw_q[1] <= cfg_wdata_i[CAL_PW_W-1:0];
          CFG_CHIP_VARIANTS: chip_var_q  <= cfg_wdata_i[CHIP_VAR_W-1:0];
          default: ;
        endcase
      end

      // in finish a free output register is reloaded below
      if (out_o.ready && (st_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end

      case (st_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            st_q <= (in_i.word.gain_reading != GAIN_OK) ? ST_FINISH : ST_PRE_VI;
          end
        end
        ST_PRE_VI: st_q <= ST_PRE_VK;
        ST_PRE_VK: begin
          qty_q <= QTY_VOLT;
          st_q  <= ST_MUL_NUM;
        end
        ST_MUL_NUM: st_q <= ST_MUL_DEN;
        ST_MUL_DEN: st_q <= ST_DIV_CHK;
        ST_DIV_CHK: begin
          cnt_q <= '0;
          if (sat_chk) begin
            if (qty_q == QTY_ENERGY) begin
              st_q <= ST_FINISH;
            end else begin
              qty_q <= qty_e'(qty_q + 1'b1);
              st_q  <= ST_MUL_NUM;
            end
          end else begin
            st_q <= ST_DIV_RUN;
          end
        end
        ST_DIV_RUN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LastCnt) begin
            if (qty_q == QTY_ENERGY) begin
              st_q <= ST_FINISH;
            end else begin
              qty_q <= qty_e'(qty_q + 1'b1);
              st_q  <= ST_MUL_NUM;
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_q            <= 1'b1;
            out_word_q.out_channel <= chan_q;
            out_word_q.chip_state  <= flags_d;
            out_word_q.comm_error  <= err_q;
            flags_q[ch_idx_q]      <= flags_d;
            if (err_q) begin
              out_word_q.voltage_mv   <= last_v_q[ch_idx_q];
              out_word_q.current_ma   <= last_i_q[ch_idx_q];
              out_word_q.power_w      <= last_p_q[ch_idx_q];
              out_word_q.energy_centi <= last_e_q[ch_idx_q];
            end else begin
              out_word_q.voltage_mv   <= res_q[QTY_VOLT];
              out_word_q.current_ma   <= res_q[QTY_CURR];
              out_word_q.power_w      <= res_q[QTY_POWER];
              out_word_q.energy_centi <= res_q[QTY_ENERGY];
              last_v_q[ch_idx_q]      <= res_q[QTY_VOLT];
              last_i_q[ch_idx_q]      <= res_q[QTY_CURR];
              last_p_q[ch_idx_q]      <= res_q[QTY_POWER];
              last_e_q[ch_idx_q]      <= res_q[QTY_ENERGY];
            end
            st_q <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* verif/testbench.sv */
module testbench;
  import emrs_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES    = 200;
  localparam int unsigned RANDOM_PHASES  = 7;
  localparam int unsigned PHASE_WORDS    = 250;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  emrs_chan_if #(.word_t(in_word_t))  reading_if ();
  emrs_chan_if #(.word_t(out_word_t)) scaled_if ();

  energy_meter_reading_scaler_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (reading_if),
    .out_o       (scaled_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // calibration copy and per-channel state
  logic [REF_V_W-1:0]    cal_ref_v;
  logic [REF_I_W-1:0]    cal_ref_i;
  logic [CAL_VI_W-1:0]   cal_vi [2];
  logic [CAL_PW_W-1:0]   cal_pw [2];
  logic [CHIP_VAR_W-1:0] cal_variants;
  logic [FLAG_W-1:0]     ch_flags [2];
  logic [RES_W-1:0]      held_volt [2];
  logic [RES_W-1:0]      held_curr [2];
  logic [RES_W-1:0]      held_power [2];
  logic [RES_W-1:0]      held_energy [2];

  out_word_t pending_scaled [$];
  out_word_t want;

  int  n_sent;
  int  n_checked = 0;
  int  n_errors = 0;
  int  n_gain_bad;
  int  n_cal_sets;
  int  rx_wait = 0;
  int  idle_cycles = 0;
  bit  no_gaps;

  function automatic int draw_gap();
    if (no_gaps || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  function automatic logic [47:0] draw_bits(int unsigned w);
    logic [63:0] r;
    logic [63:0] mask;
    r    = {$urandom, $urandom};
    mask = (64'd1 << w) - 64'd1;
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return mask[47:0];
      2:       return r[47:0] & 48'hFF;
      3:       return r[47:0];
      default: return r[47:0] & mask[47:0];
    endcase
  endfunction

  function automatic logic [RES_W-1:0] sat_ratio(logic [127:0] num, logic [127:0] den);
    logic [127:0] q;
    if (den == 0) return SAT_VAL;
    q = num / den;
    if (q > 128'hFFFF_FFFF) return SAT_VAL;
    return q[RES_W-1:0];
  endfunction

  function automatic out_word_t scale_reading(in_word_t w);
    out_word_t    r;
    logic         c;
    logic [127:0] rv, ri, vrms, irms, pwr, pulses, uk, ik, wk, mult;
    variant_e     var_sel;
    c = w.channel;
    r = '0;
    if (w.gain_reading != GAIN_OK) begin
      ch_flags[c]  = ch_flags[c] | FLAG_COMM_ERR;
      r.comm_error = 1'b1;
    end else begin
      rv     = cal_ref_v;
      ri     = cal_ref_i;
      vrms   = w.volt_rms_raw;
      irms   = w.curr_rms_raw;
      pwr    = w.power_raw;
      pwr[RAW_FIELD_W-1] = 1'b0;
      pulses = w.pulse_count_raw;
      uk     = cal_vi[c][CAL_VI_W-1:CAL_K_W];
      ik     = cal_vi[c][CAL_K_W-1:0];
      wk     = cal_pw[c];
      var_sel = variant_e'(cal_variants[2*c +: VAR_W]);
      held_volt[c] = sat_ratio(vrms * rv * 128'd1000, uk);
      if (held_volt[c] < VOLT_MIN) held_volt[c] = '0;
      held_curr[c] = sat_ratio(irms * ri, ik);
      if (held_curr[c] < CURR_MIN) held_curr[c] = '0;
      held_power[c] = sat_ratio(pwr * rv * ri, 128'd1000 * wk);
      case (var_sel)
        VAR_D78:          mult = 128'd65536;
        VAR_D70, VAR_D75: mult = 128'd4;
        default:          mult = '0;
      endcase
      if (mult == 0) held_energy[c] = '0;
      else held_energy[c] = sat_ratio(pulses * rv * ri * mult, 128'd703125 * wk);
      if (w.status_reading[OV_BIT]) ch_flags[c] = ch_flags[c] | FLAG_OVER_V;
      else ch_flags[c] = '0;
    end
    r.out_channel  = c;
    r.voltage_mv   = held_volt[c];
    r.current_ma   = held_curr[c];
    r.power_w      = held_power[c];
    r.energy_centi = held_energy[c];
    r.chip_state   = ch_flags[c];
    return r;
  endfunction

  function automatic in_word_t mk_reading(logic ch, logic [23:0] gain, logic [23:0] status,
                                          logic [23:0] vrms, logic [23:0] irms,
                                          logic [23:0] pwr, logic [23:0] pulses);
    in_word_t w;
    w.channel         = ch;
    w.gain_reading    = gain;
    w.status_reading  = status;
    w.volt_rms_raw    = vrms;
    w.curr_rms_raw    = irms;
    w.power_raw       = pwr;
    w.pulse_count_raw = pulses;
    return w;
  endfunction

  function automatic in_word_t draw_reading();
    in_word_t    w;
    logic [47:0] t;
    w.channel = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0:       w.gain_reading = RAW_FIELD_W'($urandom);
      1:       w.gain_reading = GAIN_OK ^ (24'd1 << $urandom_range(0, 23));
      default: w.gain_reading = GAIN_OK;
    endcase
    w.status_reading = RAW_FIELD_W'($urandom);
    t = draw_bits(RAW_FIELD_W); w.volt_rms_raw    = t[RAW_FIELD_W-1:0];
    t = draw_bits(RAW_FIELD_W); w.curr_rms_raw    = t[RAW_FIELD_W-1:0];
    t = draw_bits(RAW_FIELD_W); w.power_raw       = t[RAW_FIELD_W-1:0];
    t = draw_bits(RAW_FIELD_W); w.pulse_count_raw = t[RAW_FIELD_W-1:0];
    return w;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_REF_VOLTAGE:   cal_ref_v    = val[REF_V_W-1:0];
      CFG_REF_CURRENT:   cal_ref_i    = val[REF_I_W-1:0];
      CFG_CAL_VI_CH0:    cal_vi[0]    = val[CAL_VI_W-1:0];
      CFG_CAL_VI_CH1:    cal_vi[1]    = val[CAL_VI_W-1:0];
      CFG_CAL_POWER_CH0: cal_pw[0]    = val[CAL_PW_W-1:0];
      CFG_CAL_POWER_CH1: cal_pw[1]    = val[CAL_PW_W-1:0];
      CFG_CHIP_VARIANTS: cal_variants = val[CHIP_VAR_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    n_cal_sets++;
  endtask

  // valid stays high after acceptance so back-to-back words need no toggle
  task automatic send_reading(in_word_t w);
    int gap;
    gap = draw_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      reading_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    reading_if.valid <= 1'b1;
    reading_if.word  <= w;
    do @(posedge clk_i); while (!reading_if.ready);
    pending_scaled.push_back(scale_reading(w));
    if (w.gain_reading != GAIN_OK) n_gain_bad++;
    n_sent++;
  endtask

  task automatic drain_pending();
    @(negedge clk_i);
    reading_if.valid <= 1'b0;
    while (pending_scaled.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic [RES_W-1:0] exp_v, logic [RES_W-1:0] act_v);
    if (exp_v !== act_v) begin
      n_errors++;
      $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && scaled_if.valid && scaled_if.ready) begin
      if (pending_scaled.size() == 0) begin
        n_errors++;
        $display("%0t unexpected word: expected none actual %h", $time, scaled_if.word);
      end else begin
        want = pending_scaled.pop_front();
        check_field("out_channel", want.out_channel, scaled_if.word.out_channel);
        check_field("voltage_mv", want.voltage_mv, scaled_if.word.voltage_mv);
        check_field("current_ma", want.current_ma, scaled_if.word.current_ma);
        check_field("power_w", want.power_w, scaled_if.word.power_w);
        check_field("energy_centi", want.energy_centi, scaled_if.word.energy_centi);
        check_field("chip_state", want.chip_state, scaled_if.word.chip_state);
        check_field("comm_error", want.comm_error, scaled_if.word.comm_error);
      end
      n_checked++;
      rx_wait = draw_gap();
    end
  end

  always @(negedge clk_i) begin
    if (rx_wait > 0) begin
      scaled_if.ready <= 1'b0;
      rx_wait--;
    end else begin
      scaled_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((reading_if.valid && reading_if.ready) || (scaled_if.valid && scaled_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no handshake for %0d cycles", $time, idle_cycles);
      $display("FAIL energy_meter_reading_scaler_core");
      $finish;
    end
  end

  // zero calibration saturates, unknown variant gives no energy, flags sticky/clear
  task automatic test_reset_defaults();
    send_reading(mk_reading(1'b0, GAIN_OK, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0));
    send_reading(mk_reading(1'b1, 24'h0, 24'hFFFFFF, 24'h123456, 24'h1, 24'h2, 24'h3));
    send_reading(mk_reading(1'b1, GAIN_OK, 24'h000020, 24'hFFFFFF, 24'hFFFFFF,
                            24'hFFFFFF, 24'hFFFFFF));
    send_reading(mk_reading(1'b1, GAIN_OK, 24'hFFFFDF, 24'h1, 24'h1, 24'h1, 24'h1));
    drain_pending();
  endtask

  task automatic test_special_cases();
    write_reg(CFG_REF_VOLTAGE, 48'd230);
    write_reg(CFG_REF_CURRENT, 48'd5000);
    write_reg(CFG_CAL_VI_CH0, {24'h100000, 24'h004000});
    write_reg(CFG_CAL_VI_CH1, {24'h000001, 24'h000001});
    write_reg(CFG_CAL_POWER_CH0, 48'h001000);
    write_reg(CFG_CAL_POWER_CH1, 48'h7FFFFF);
    write_reg(CFG_CHIP_VARIANTS, CFG_DATA_W'({VAR_D70, VAR_D78}));
    // just below and just above the voltage and current floors, top power bit
    send_reading(mk_reading(1'b0, GAIN_OK, 24'h0, 24'd4000, 24'd30, 24'h800000, 24'd1000));
    send_reading(mk_reading(1'b0, GAIN_OK, 24'h000020, 24'd4600, 24'd33, 24'h7FFFFF,
                            24'hFFFFFF));
    send_reading(mk_reading(1'b0, 24'h000032, 24'h0, 24'h1, 24'h1, 24'h1, 24'h1));
    send_reading(mk_reading(1'b0, 24'hFFFFFF, 24'h000020, 24'h1, 24'h1, 24'h1, 24'h1));
    send_reading(mk_reading(1'b0, GAIN_OK, 24'h0, 24'd50000, 24'd900, 24'd12345, 24'd77));
    send_reading(mk_reading(1'b1, GAIN_OK, 24'h0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                            24'hFFFFFF));
    send_reading(mk_reading(1'b1, GAIN_OK, 24'h0, 24'd3, 24'd1, 24'd5, 24'd2));
    drain_pending();
    write_reg(CFG_CHIP_VARIANTS, CFG_DATA_W'({VAR_UNKNOWN, VAR_D75}));
    send_reading(mk_reading(1'b0, GAIN_OK, 24'h0, 24'd9000, 24'd500, 24'd400, 24'hFFFFFF));
    send_reading(mk_reading(1'b1, GAIN_OK, 24'h0, 24'd9000, 24'd500, 24'd400, 24'hFFFFFF));
    drain_pending();
  endtask

  task automatic test_config_extremes();
    write_reg(CFG_REF_VOLTAGE, '1);
    write_reg(CFG_REF_CURRENT, '1);
    write_reg(CFG_CAL_VI_CH0, '1);
    write_reg(CFG_CAL_VI_CH1, '1);
    write_reg(CFG_CAL_POWER_CH0, '1);
    write_reg(CFG_CAL_POWER_CH1, '1);
    write_reg(CFG_CHIP_VARIANTS, '1);
    write_reg(CFG_UNUSED_IDX, '0);
    send_reading(mk_reading(1'b0, GAIN_OK, 24'h0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                            24'hFFFFFF));
    send_reading(mk_reading(1'b1, GAIN_OK, 24'hFFFFFF, 24'h0, 24'h0, 24'h0, 24'h0));
    send_reading(mk_reading(1'b1, GAIN_OK, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                            24'hFFFFFF, 24'hFFFFFF));
    drain_pending();
    write_reg(CFG_REF_VOLTAGE, '0);
    write_reg(CFG_REF_CURRENT, '0);
    write_reg(CFG_CAL_VI_CH0, {24'h000001, 24'h000001});
    write_reg(CFG_CAL_VI_CH1, '0);
    write_reg(CFG_CAL_POWER_CH0, '0);
    write_reg(CFG_CAL_POWER_CH1, '0);
    write_reg(CFG_CHIP_VARIANTS, CFG_DATA_W'({VAR_D78, VAR_D78}));
    send_reading(mk_reading(1'b0, GAIN_OK, 24'h0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                            24'hFFFFFF));
    send_reading(mk_reading(1'b1, GAIN_OK, 24'h0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                            24'hFFFFFF));
    send_reading(mk_reading(1'b1, 24'h000013, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0));
    drain_pending();
  endtask

  task automatic test_random_phases();
    logic [47:0] hi;
    logic [47:0] lo;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      no_gaps = (ph % 3 == 1);
      hi = draw_bits(CAL_K_W);
      lo = draw_bits(CAL_K_W);
      write_reg(CFG_REF_VOLTAGE, draw_bits(REF_V_W));
      write_reg(CFG_REF_CURRENT, draw_bits(REF_I_W));
      write_reg(CFG_CAL_VI_CH0, {hi[CAL_K_W-1:0], lo[CAL_K_W-1:0]});
      hi = draw_bits(CAL_K_W);
      lo = draw_bits(CAL_K_W);
      write_reg(CFG_CAL_VI_CH1, {hi[CAL_K_W-1:0], lo[CAL_K_W-1:0]});
      write_reg(CFG_CAL_POWER_CH0, draw_bits(CAL_PW_W));
      write_reg(CFG_CAL_POWER_CH1, draw_bits(CAL_PW_W));
      write_reg(CFG_CHIP_VARIANTS, CFG_DATA_W'($urandom_range(0, 15)));
      for (int k = 0; k < PHASE_WORDS; k++) begin
        // hold the sender until the block has emptied once mid-phase
        if (ph == 2 && k == PHASE_WORDS / 2) drain_pending();
        send_reading(draw_reading());
      end
      drain_pending();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_REF_VOLTAGE;
    cfg_wdata_i       = '0;
    reading_if.valid  = 1'b0;
    reading_if.word   = '0;
    no_gaps           = 1'b0;
    n_sent            = 0;
    n_gain_bad        = 0;
    n_cal_sets        = 0;
    cal_ref_v         = REF_V_RST;
    cal_ref_i         = REF_I_RST;
    cal_variants      = '0;
    for (int c = 0; c < 2; c++) begin
      cal_vi[c]      = '0;
      cal_pw[c]      = '0;
      ch_flags[c]    = '0;
      held_volt[c]   = '0;
      held_curr[c]   = '0;
      held_power[c]  = '0;
      held_energy[c] = '0;
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_special_cases();
    test_config_extremes();
    test_random_phases();

    drain_pending();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d reading words sent (%0d with bad gain), %0d scaled words checked",
             n_sent, n_gain_bad, n_checked);
    $display("%0d register writes over reset, directed and random calibrations, %0d errors",
             n_cal_sets, n_errors);
    if (n_errors == 0) begin
      $display("PASS energy_meter_reading_scaler_core");
    end else begin
      $display("FAIL energy_meter_reading_scaler_core");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/emrs_pkg.sv
rtl/core/emrs_chan_if.sv
rtl/core/energy_meter_reading_scaler_core.sv
verif/testbench.sv
